// ===== hdl/dwts_pkg.sv =====
// Shared types, constants and tables for the DDS wave table sample core.
// Holds the quarter-wave sine ROM and the reciprocal constants of the divider.
// No dependencies.
`default_nettype none

package dwts_pkg;

   localparam int PHASE_W  = 9;
   localparam int SAMPLE_W = 16;
   localparam int AMP_W    = 15;
   localparam int DUTY_W   = 7;
   localparam int SHAPE_W  = 3;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 4;

   // Widths of one sample through the datapath.
   localparam int MULT_W = 15;                // multiplicand: ROM entry or index
   localparam int PROD_W = AMP_W + MULT_W;    // amplitude times multiplicand
   localparam int NUM_W  = 25;                // dividend for the constant divider
   localparam int RECIP_W = 26;
   localparam int QUOT_W = 16;

   localparam logic [PHASE_W-1:0] POINTS_PER_PERIOD = 9'd360;
   localparam logic [PHASE_W-1:0] HALF_PERIOD       = 9'd180;
   localparam logic [PHASE_W-1:0] QUARTER_PERIOD    = 9'd90;
   localparam logic [PHASE_W-1:0] THREE_QUARTERS    = 9'd270;

   localparam logic [SAMPLE_W-1:0] MIDSCALE = 16'h7FFF;

   // Negative sine half rounds the magnitude up: add 2^15 - 1 before the shift.
   localparam logic [PROD_W-1:0] SINE_ROUND = 30'd32767;

   // Ceiling division biases (divisor minus one).
   localparam logic [NUM_W-1:0] TRI_BIAS = 25'd178;
   localparam logic [NUM_W-1:0] SAW_BIAS = 25'd358;

   // floor(n / 179) = (n * ceil(2^32 / 179)) >> 32 for n below 2^24.
   // floor(n / 359) = (n * ceil(2^34 / 359)) >> 34 for n below 2^25.
   localparam logic [RECIP_W-1:0] TRI_RECIP = 26'd23994231;
   localparam logic [RECIP_W-1:0] SAW_RECIP = 26'd47854789;
   localparam int TRI_SHIFT = 32;
   localparam int SAW_SHIFT = 34;

   // Square threshold: 360 * (100 - d) / 100 = (18 * (100 - d)) / 5, and
   // floor(y / 5) = (y * 3277) >> 14 for y below 2^11.
   localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
   localparam logic [4:0]        DUTY_SCALE = 5'd18;
   localparam logic [11:0]       DIV5_RECIP = 12'd3277;
   localparam int                DIV5_SHIFT = 14;

   // Shape register codes.
   localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd2;
   localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 3'd3;
   localparam logic [SHAPE_W-1:0] SHAPE_REV_SAW  = 3'd4;
   localparam logic [SHAPE_W-1:0] SHAPE_FLAT     = 3'd5;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_WAVE_SHAPE   = 2'd0;
   localparam logic [1:0] CSR_AMPLITUDE    = 2'd1;
   localparam logic [1:0] CSR_DUTY_PERCENT = 2'd2;

   typedef enum logic {
      DIV_TRI,
      DIV_SAW
   } div_sel_type;

   // round(32767 * sin(k degrees)), k = 0..90.
   localparam logic [MULT_W-1:0] QUARTER_SINE [0:90] = '{
          15'd0,   15'd572,  15'd1144,  15'd1715,  15'd2286,
       15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
       15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
       15'd8481,  15'd9032,  15'd9580, 15'd10126, 15'd10668,
      15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
      15'd13848, 15'd14364, 15'd14876, 15'd15383, 15'd15886,
      15'd16384, 15'd16876, 15'd17364, 15'd17846, 15'd18323,
      15'd18794, 15'd19260, 15'd19720, 15'd20173, 15'd20621,
      15'd21062, 15'd21497, 15'd21925, 15'd22347, 15'd22762,
      15'd23170, 15'd23571, 15'd23964, 15'd24351, 15'd24730,
      15'd25101, 15'd25465, 15'd25821, 15'd26169, 15'd26509,
      15'd26841, 15'd27165, 15'd27481, 15'd27788, 15'd28087,
      15'd28377, 15'd28659, 15'd28932, 15'd29196, 15'd29451,
      15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591,
      15'd30791, 15'd30982, 15'd31163, 15'd31335, 15'd31498,
      15'd31650, 15'd31794, 15'd31927, 15'd32051, 15'd32165,
      15'd32269, 15'd32364, 15'd32448, 15'd32523, 15'd32587,
      15'd32642, 15'd32687, 15'd32722, 15'd32747, 15'd32762,
      15'd32767
   };

endpackage

`default_nettype wire

// ===== hdl/dwts_const_div.sv =====
// Pipelined divider by the constants 179 or 359, built as a reciprocal multiply.
// Depends on dwts_pkg for the reciprocals, shifts and the divisor select type.
`default_nettype none

module dwts_const_div
   import dwts_pkg::*;
(
   input  logic              clock,
   input  logic [NUM_W-1:0]  div_n,
   input  div_sel_type       div_sel,
   output logic [QUOT_W-1:0] div_q
);

   localparam int FULL_W = NUM_W + RECIP_W;

   logic [RECIP_W-1:0] recip;
   logic [FULL_W-1:0]  prod_in;
   logic [FULL_W-1:0]  prod_ff;
   div_sel_type        sel_ff;

   assign recip   = (div_sel == DIV_SAW) ? SAW_RECIP : TRI_RECIP;
   assign prod_in = FULL_W'(div_n) * FULL_W'(recip);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sel_ff  <= div_sel;
   end

   // The quotient fits 16 bits for every dividend the core produces.
   assign div_q = (sel_ff == DIV_SAW) ? prod_ff[SAW_SHIFT +: QUOT_W]
                                      : prod_ff[TRI_SHIFT +: QUOT_W];

endmodule

`default_nettype wire

// ===== hdl/dds_wave_table_sample_core.sv =====
// Top level of the DDS wave table sample core: configuration registers and
// the sample datapath. Depends on dwts_pkg and dwts_const_div.
//
// Usage. A phase index (degrees) is offered on req_phase_index with start
// high; the transaction is accepted at a rising edge where start is high and
// busy is low. Indexes 360 to 511 wrap by subtracting 360. Exactly one
// sample comes back per accepted transaction on rsp_sample, marked by
// rsp_valid for a single cycle, in order. The core takes one transaction
// every cycle while busy is low: the datapath is a six-register pipeline
// (input, ROM/fold, amplitude multiply, bias add, reciprocal multiply,
// output), so throughput is one sample per clock. The receiver cannot
// stall; results are never held back. Shape, amplitude and duty are set
// on the APB-style port at byte addresses 0, 4 and 8; the user must change
// them only while no transaction is in flight; the core does not enforce
// this. Synchronous reset clears the valid pipeline, sets the shape to flat
// midscale, amplitude to zero and duty to fifty percent; busy is high while
// reset is applied and for the cycle after, and low at all other times.
`default_nettype none

module dds_wave_table_sample_core
   import dwts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Sample request channel
   input  logic                start,
   input  logic [PHASE_W-1:0]  req_phase_index,
   output logic                busy,
   // Sample result channel
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] rsp_sample,
   // Configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [CSR_W-1:0]    pwdata,
   output logic [CSR_W-1:0]    prdata,
   output logic                pready
);

   typedef enum logic [3:0] {
      M_FLAT,
      M_SQ_LOW,
      M_SQ_HIGH,
      M_SINE_POS,
      M_SINE_NEG,
      M_TRI_UP,
      M_TRI_DOWN,
      M_SAW_UP,
      M_SAW_DOWN
   } mode_type;

   localparam int STAGES = 5;

   // Configuration registers.
   logic [SHAPE_W-1:0] wave_shape_ff;
   logic [AMP_W-1:0]   amplitude_ff;
   logic [DUTY_W-1:0]  duty_percent_ff;
   logic               csr_write;
   logic [1:0]         csr_index;

   // Control.
   logic               busy_ff;
   logic               accept;
   logic [STAGES-1:0]  vld_ff;
   logic               rsp_valid_ff;

   // Datapath.
   logic [PHASE_W-1:0]  idx_in, idx_ff;
   logic [MULT_W-1:0]   mult_in, mult_ff;
   mode_type            mode_b_in, mode_b_ff;
   logic [PROD_W-1:0]   prod_ff;
   mode_type            mode_c_ff;
   logic [PROD_W-1:0]   num_in, num_ff;
   mode_type            mode_d_ff;
   logic [AMP_W-1:0]    sine_q_ff;
   mode_type            mode_e_ff;
   div_sel_type         div_sel;
   logic [QUOT_W-1:0]   div_q;
   logic [SAMPLE_W:0]   sample_wide;
   logic [SAMPLE_W-1:0] rsp_sample_ff;

   // Fold and square threshold helpers.
   logic [PHASE_W-1:0] fold_idx;
   logic               fold_neg;
   logic [DUTY_W-1:0]  duty_sat;
   logic [10:0]        sq_scaled;
   logic [22:0]        sq_prod;
   logic [PHASE_W-1:0] sq_thr;

   // ---------------------------------------------------------------------
   // Configuration port. Writes land on the access phase; pready is tied
   // high so every transaction completes without wait states.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_shape_ff   <= SHAPE_FLAT;
         amplitude_ff    <= '0;
         duty_percent_ff <= 7'd50;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WAVE_SHAPE:   wave_shape_ff   <= pwdata[SHAPE_W-1:0];
            CSR_AMPLITUDE:    amplitude_ff    <= pwdata[AMP_W-1:0];
            CSR_DUTY_PERCENT: duty_percent_ff <= pwdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_WAVE_SHAPE:   prdata = CSR_W'(wave_shape_ff);
         CSR_AMPLITUDE:    prdata = CSR_W'(amplitude_ff);
         CSR_DUTY_PERCENT: prdata = CSR_W'(duty_percent_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake and valid pipeline. Busy only guards the reset window.
   // ---------------------------------------------------------------------
   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         vld_ff       <= {vld_ff[STAGES-2:0], accept};
         rsp_valid_ff <= vld_ff[STAGES-1];
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: input register holds the index wrapped into one period.
   // ---------------------------------------------------------------------
   assign idx_in = (req_phase_index >= POINTS_PER_PERIOD)
                 ? req_phase_index - POINTS_PER_PERIOD : req_phase_index;

   // ---------------------------------------------------------------------
   // Stage B: pick the multiplicand and the mode. Sine folds the index into
   // the first quadrant and reads the quarter-wave ROM; square compares the
   // index with the duty threshold.
   // ---------------------------------------------------------------------
   always_comb begin
      if (idx_ff <= QUARTER_PERIOD) begin
         fold_idx = idx_ff;
         fold_neg = 1'b0;
      end else if (idx_ff <= HALF_PERIOD) begin
         fold_idx = HALF_PERIOD - idx_ff;
         fold_neg = 1'b0;
      end else if (idx_ff <= THREE_QUARTERS) begin
         fold_idx = idx_ff - HALF_PERIOD;
         fold_neg = 1'b1;
      end else begin
         fold_idx = POINTS_PER_PERIOD - idx_ff;
         fold_neg = 1'b1;
      end
   end

   assign duty_sat  = (duty_percent_ff > DUTY_MAX) ? DUTY_MAX : duty_percent_ff;
   assign sq_scaled = 11'(DUTY_SCALE) * 11'(DUTY_MAX - duty_sat);
   assign sq_prod   = 23'(sq_scaled) * 23'(DIV5_RECIP);
   assign sq_thr    = sq_prod[DIV5_SHIFT +: PHASE_W];

   always_comb begin
      mult_in   = MULT_W'(idx_ff);
      mode_b_in = M_FLAT;
      case (wave_shape_ff)
         SHAPE_SINE: begin
            mult_in   = QUARTER_SINE[fold_idx[6:0]];
            mode_b_in = fold_neg ? M_SINE_NEG : M_SINE_POS;
         end
         SHAPE_SQUARE: begin
            mode_b_in = (idx_ff < sq_thr) ? M_SQ_LOW : M_SQ_HIGH;
         end
         SHAPE_TRIANGLE: begin
            if (idx_ff < HALF_PERIOD) begin
               mode_b_in = M_TRI_UP;
            end else begin
               mult_in   = MULT_W'(idx_ff - HALF_PERIOD);
               mode_b_in = M_TRI_DOWN;
            end
         end
         SHAPE_SAW:     mode_b_in = M_SAW_UP;
         SHAPE_REV_SAW: mode_b_in = M_SAW_DOWN;
         default:       mode_b_in = M_FLAT;
      endcase
   end

   // ---------------------------------------------------------------------
   // Stage D: form the dividend. Ramps use twice the product, biased by the
   // divisor minus one where the ramp needs the ceiling. Negative sine adds
   // the rounding term ahead of the 15-bit shift.
   // ---------------------------------------------------------------------
   always_comb begin
      case (mode_c_ff)
         M_SINE_NEG:          num_in = prod_ff + SINE_ROUND;
         M_TRI_UP, M_SAW_UP:  num_in = {prod_ff[PROD_W-2:0], 1'b0};
         M_TRI_DOWN:          num_in = {prod_ff[PROD_W-2:0], 1'b0} + PROD_W'(TRI_BIAS);
         M_SAW_DOWN:          num_in = {prod_ff[PROD_W-2:0], 1'b0} + PROD_W'(SAW_BIAS);
         default:             num_in = prod_ff;
      endcase
   end

   assign div_sel = (mode_d_ff == M_TRI_UP || mode_d_ff == M_TRI_DOWN) ? DIV_TRI : DIV_SAW;

   // Stage E: the reciprocal multiply runs inside the divider.
   dwts_const_div u_div (
      .clock   (clock),
      .div_n   (num_ff[NUM_W-1:0]),
      .div_sel (div_sel),
      .div_q   (div_q)
   );

   // ---------------------------------------------------------------------
   // Stage F: assemble the sample around midscale. Every case stays within
   // 0..65535 because the amplitude is at most 0x7FFF.
   // ---------------------------------------------------------------------
   always_comb begin
      case (mode_e_ff)
         M_SQ_LOW:   sample_wide = 17'(MIDSCALE) - 17'(amplitude_ff);
         M_SQ_HIGH:  sample_wide = 17'(MIDSCALE) + 17'(amplitude_ff);
         M_SINE_POS: sample_wide = 17'(MIDSCALE) + 17'(sine_q_ff);
         M_SINE_NEG: sample_wide = 17'(MIDSCALE) - 17'(sine_q_ff);
         M_TRI_UP, M_SAW_UP:
            sample_wide = 17'(MIDSCALE) - 17'(amplitude_ff) + 17'(div_q);
         M_TRI_DOWN:
            sample_wide = 17'(MIDSCALE) + 17'(amplitude_ff) + 17'd1 - 17'(div_q);
         M_SAW_DOWN:
            sample_wide = 17'(MIDSCALE) + 17'(amplitude_ff) - 17'(div_q);
         default:    sample_wide = 17'(MIDSCALE);
      endcase
   end

   // Payload registers load every cycle; the valid pipeline marks live data.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      mult_ff       <= mult_in;
      mode_b_ff     <= mode_b_in;
      prod_ff       <= PROD_W'(amplitude_ff) * PROD_W'(mult_ff);
      mode_c_ff     <= mode_b_ff;
      num_ff        <= num_in;
      mode_d_ff     <= mode_c_ff;
      sine_q_ff     <= num_ff[PROD_W-1:PROD_W-AMP_W];
      mode_e_ff     <= mode_d_ff;
      rsp_sample_ff <= sample_wide[SAMPLE_W-1:0];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

`default_nettype wire

// ===== hdl/dwts_checker.sv =====
// Port-level checker for the DDS wave table sample core, bound to the top level.
// Depends on dwts_pkg for widths and register indexes.
`default_nettype none

module dwts_checker
   import dwts_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic                psel,
   input logic                pwrite,
   input logic [ADDR_W-1:0]   paddr,
   input logic [CSR_W-1:0]    prdata
);

   // Every accepted transaction yields its sample on rsp_valid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("accepted transaction produced no result on time");

   // No result appears without a matching accepted transaction.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result without a matching accepted transaction");

   // Once out of reset the core never asserts busy again.
   a_busy_stays_low: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !busy)
      else $error("busy rose outside reset");

   // The shape register reads back zero-extended.
   a_shape_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && !pwrite && paddr[3:2] == CSR_WAVE_SHAPE) |-> prdata[CSR_W-1:SHAPE_W] == '0)
      else $error("shape register read returned stray upper bits");

endmodule

bind dds_wave_table_sample_core dwts_checker u_dwts_checker (.*);

`default_nettype wire
